@@ design/toh_pkg.sv @@
`default_nettype none

package toh_pkg;

   localparam int SPAN        = 8;
   localparam int BIN_SHIFT   = 5;
   localparam int BIN_W       = 16;
   localparam int TILE_FULL_W = BIN_W - BIN_SHIFT;
   localparam int CNT_W       = 4;
   localparam int TILE_W      = 7;
   localparam int AMT_W       = 2 * CNT_W;
   localparam int IDX_W       = 12;
   localparam int OUT_W       = 32;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_X_BIN_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_BIN_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_TILES     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_TILES     = 2'd3;

   typedef enum logic [1:0] {
      OP_COUNT = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // per-axis scan result: base tile plus kept-bin counts in base tile and the next one
   typedef struct packed {
      logic [TILE_W-1:0] tile;
      logic [CNT_W-1:0]  cnt_a;
      logic [CNT_W-1:0]  cnt_b;
   } axis_type;

   typedef struct packed {
      op_type            op;
      axis_type          x_axis;
      axis_type          y_axis;
      logic [TILE_W-1:0] y_tiles;
      logic [IDX_W-1:0]  read_index;
   } work_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

endpackage

`default_nettype wire

@@ design/toh_queue.sv @@
`default_nettype none

module toh_queue
   import toh_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  var  work_type in_data,
   output logic          out_valid,
   input  wire logic     out_ready,
   output work_type      out_data
);

   work_type   slots_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_data  = slots_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

@@ design/toh_front.sv @@
`default_nettype none

module toh_front
   import toh_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_operation,
   input  wire logic signed [BIN_W-1:0] req_bin_x_low,
   input  wire logic signed [BIN_W-1:0] req_bin_y_low,
   input  wire logic [SPAN-1:0]        req_x_overlap_flags,
   input  wire logic [SPAN-1:0]        req_y_overlap_flags,
   input  wire logic [IDX_W-1:0]       req_read_index,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [BIN_W-1:0]       csr_data,
   input  var  back_status_type        status,
   output logic                        q_valid,
   input  wire logic                   q_ready,
   output work_type                    q_data
);

   logic [BIN_W-1:0]  x_bin_limit_ff, x_bin_limit_in;
   logic [BIN_W-1:0]  y_bin_limit_ff, y_bin_limit_in;
   logic [TILE_W-1:0] x_tiles_ff, x_tiles_in;
   logic [TILE_W-1:0] y_tiles_ff, y_tiles_in;
   logic              known_op;

   // walk the flags in order; two clear flags in a row stop the walk
   function automatic axis_type scan_axis(logic [BIN_W-1:0] low, logic [SPAN-1:0] flags,
                                          logic [BIN_W-1:0] limit, logic [TILE_W-1:0] tiles);
      axis_type               r;
      logic                   alive;
      logic                   prev_clear;
      logic [BIN_W:0]         b;
      logic [BIN_W-1:0]       bin;
      logic [TILE_FULL_W-1:0] tl;
      logic [TILE_FULL_W-1:0] base;
      base       = low[BIN_W-1] ? '0 : low[BIN_W-1:BIN_SHIFT];
      r.tile     = base[TILE_W-1:0];
      r.cnt_a    = '0;
      r.cnt_b    = '0;
      alive      = 1'b1;
      prev_clear = 1'b0;
      for (int j = 0; j < SPAN; j++) begin
         b   = {low[BIN_W-1], low} + (BIN_W+1)'(j);
         bin = b[BIN_W-1:0];
         tl  = bin[BIN_W-1:BIN_SHIFT];
         if (alive) begin
            if (!flags[j]) begin
               if (prev_clear) begin
                  alive = 1'b0;
               end
               prev_clear = 1'b1;
            end else begin
               prev_clear = 1'b0;
               if (!b[BIN_W] && (bin < limit) && (tl < TILE_FULL_W'(tiles))) begin
                  if (tl == base) begin
                     r.cnt_a = r.cnt_a + CNT_W'(1);
                  end else begin
                     r.cnt_b = r.cnt_b + CNT_W'(1);
                  end
               end
            end
         end
      end
      return r;
   endfunction

   always_comb begin
      unique case (req_operation)
         OP_COUNT, OP_READ, OP_CLEAR: known_op = 1'b1;
         default:                     known_op = 1'b0;
      endcase
   end

   // unknown codes are taken and dropped
   assign req_ready = !status.init_busy && q_ready;
   assign q_valid   = req_valid && !status.init_busy && known_op;
   assign csr_ready = 1'b1;

   always_comb begin
      q_data.op         = op_type'(req_operation);
      q_data.x_axis     = scan_axis(req_bin_x_low, req_x_overlap_flags, x_bin_limit_ff,
                                    x_tiles_ff);
      q_data.y_axis     = scan_axis(req_bin_y_low, req_y_overlap_flags, y_bin_limit_ff,
                                    y_tiles_ff);
      q_data.y_tiles    = y_tiles_ff;
      q_data.read_index = req_read_index;
   end

   always_comb begin
      x_bin_limit_in = x_bin_limit_ff;
      y_bin_limit_in = y_bin_limit_ff;
      x_tiles_in     = x_tiles_ff;
      y_tiles_in     = y_tiles_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_X_BIN_LIMIT: x_bin_limit_in = csr_data;
            CSR_Y_BIN_LIMIT: y_bin_limit_in = csr_data;
            CSR_X_TILES:     x_tiles_in     = csr_data[TILE_W-1:0];
            CSR_Y_TILES:     y_tiles_in     = csr_data[TILE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_bin_limit_ff <= BIN_W'(2048);
         y_bin_limit_ff <= BIN_W'(2048);
         x_tiles_ff     <= TILE_W'(64);
         y_tiles_ff     <= TILE_W'(64);
      end else begin
         x_bin_limit_ff <= x_bin_limit_in;
         y_bin_limit_ff <= y_bin_limit_in;
         x_tiles_ff     <= x_tiles_in;
         y_tiles_ff     <= y_tiles_in;
      end
   end

endmodule

`default_nettype wire

@@ design/toh_back.sv @@
`default_nettype none

module toh_back
   import toh_pkg::*;
#(
   parameter int MAX_TILES   = 4096,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   output logic                  q_pop,
   input  var  work_type         head,
   output back_status_type       status,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [OUT_W-1:0]      rsp_tile_count,
   output logic [IDX_W-1:0]      rsp_tile_index
);

   localparam int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

   typedef enum logic [1:0] {
      S_INIT,
      S_RUN,
      S_CLEAR
   } state_type;

   state_type              state_ff, state_in;
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic [1:0]             slot_ff, slot_in;
   logic                   s2_valid_ff, s2_valid_in;
   logic                   s2_read_ff, s2_read_in;
   logic [AW-1:0]          s2_addr_ff, s2_addr_in;
   logic [AMT_W-1:0]       s2_amt_ff, s2_amt_in;
   logic                   s2_zero_ff, s2_zero_in;
   logic [IDX_W-1:0]       s2_index_ff, s2_index_in;
   logic                   s2_fwd_ff, s2_fwd_in;
   logic [COUNT_WIDTH-1:0] s2_fwd_data_ff, s2_fwd_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic [IDX_W-1:0]       rsp_index_ff, rsp_index_in;

   logic [COUNT_WIDTH-1:0] mem [MAX_TILES];
   logic [COUNT_WIDTH-1:0] mem_q_ff;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [COUNT_WIDTH-1:0] mem_wdata;
   logic                   issue;
   logic [AW-1:0]          issue_addr;
   logic                   sweep_we;

   logic [COUNT_WIDTH-1:0] cur_count;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic [63:0]            cur_wide;

   logic [TILE_W-1:0]      tx;
   logic [TILE_W-1:0]      ty;
   logic [CNT_W-1:0]       cx;
   logic [CNT_W-1:0]       cy;
   logic [AMT_W-1:0]       amt;
   logic [2*TILE_W-1:0]    prod;
   logic [2*TILE_W:0]      idx_full;
   logic [31:0]            idx_w;
   logic [AW-1:0]          slot_addr;
   logic                   slot_active;
   logic [31:0]            rd_w;
   logic [AW-1:0]          rd_addr;
   logic                   rd_in_range;

   // count from memory, or the value written alongside the read when both hit the same entry
   assign cur_count = s2_fwd_ff ? s2_fwd_data_ff : mem_q_ff;
   assign wr_data   = cur_count + COUNT_WIDTH'(s2_amt_ff);
   assign cur_wide  = 64'(cur_count);

   // slot bit 1 picks the x tile, bit 0 the y tile
   always_comb begin
      tx          = head.x_axis.tile + TILE_W'(slot_ff[1]);
      ty          = head.y_axis.tile + TILE_W'(slot_ff[0]);
      cx          = slot_ff[1] ? head.x_axis.cnt_b : head.x_axis.cnt_a;
      cy          = slot_ff[0] ? head.y_axis.cnt_b : head.y_axis.cnt_a;
      amt         = {{CNT_W{1'b0}}, cx} * {{CNT_W{1'b0}}, cy};
      prod        = {{TILE_W{1'b0}}, tx} * {{TILE_W{1'b0}}, head.y_tiles};
      idx_full    = (2*TILE_W+1)'(prod) + (2*TILE_W+1)'(ty);
      idx_w       = 32'(idx_full);
      slot_addr   = idx_w[AW-1:0];
      slot_active = (amt != '0) && (17'(idx_full) < 17'(MAX_TILES));
      rd_w        = 32'(head.read_index);
      rd_addr     = rd_w[AW-1:0];
      rd_in_range = 17'(head.read_index) < 17'(MAX_TILES);
   end

   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      slot_in        = slot_ff;
      q_pop          = 1'b0;
      issue          = 1'b0;
      issue_addr     = slot_addr;
      sweep_we       = 1'b0;
      s2_valid_in    = 1'b0;
      s2_read_in     = 1'b0;
      s2_addr_in     = s2_addr_ff;
      s2_amt_in      = s2_amt_ff;
      s2_zero_in     = s2_zero_ff;
      s2_index_in    = s2_index_ff;
      s2_fwd_in      = 1'b0;
      s2_fwd_data_in = s2_fwd_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_count_in   = rsp_count_ff;
      rsp_index_in   = rsp_index_ff;

      if (s2_read_ff) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = s2_zero_ff ? '0 : cur_wide[OUT_W-1:0];
         rsp_index_in = s2_index_ff;
      end

      unique case (state_ff)
         S_INIT, S_CLEAR: begin
            sweep_we = 1'b1;
            ptr_in   = ptr_ff + AW'(1);
            if (ptr_ff == AW'(MAX_TILES - 1)) begin
               state_in = S_RUN;
               ptr_in   = '0;
            end
         end
         S_RUN: begin
            if (q_valid) begin
               unique case (head.op)
                  OP_COUNT: begin
                     if (slot_active) begin
                        issue       = 1'b1;
                        issue_addr  = slot_addr;
                        s2_valid_in = 1'b1;
                        s2_addr_in  = slot_addr;
                        s2_amt_in   = amt;
                     end
                     slot_in = slot_ff + 2'd1;
                     if (slot_ff == 2'd3) begin
                        q_pop = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (!rsp_valid_ff && !s2_read_ff) begin
                        q_pop       = 1'b1;
                        s2_read_in  = 1'b1;
                        s2_index_in = head.read_index;
                        s2_zero_in  = !rd_in_range;
                        issue       = rd_in_range;
                        issue_addr  = rd_addr;
                     end
                  end
                  OP_CLEAR: begin
                     if (!s2_valid_ff && !s2_read_ff) begin
                        q_pop    = 1'b1;
                        state_in = S_CLEAR;
                        ptr_in   = '0;
                     end
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         default: state_in = S_INIT;
      endcase

      if (issue && s2_valid_ff && (s2_addr_ff == issue_addr)) begin
         s2_fwd_in      = 1'b1;
         s2_fwd_data_in = wr_data;
      end
   end

   always_comb begin
      mem_we    = sweep_we || s2_valid_ff;
      mem_waddr = sweep_we ? ptr_ff : s2_addr_ff;
      mem_wdata = sweep_we ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (issue) begin
         mem_q_ff <= mem[issue_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         ptr_ff       <= '0;
         slot_ff      <= 2'd0;
         s2_valid_ff  <= 1'b0;
         s2_read_ff   <= 1'b0;
         s2_fwd_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         slot_ff      <= slot_in;
         s2_valid_ff  <= s2_valid_in;
         s2_read_ff   <= s2_read_in;
         s2_fwd_ff    <= s2_fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s2_addr_ff     <= s2_addr_in;
      s2_amt_ff      <= s2_amt_in;
      s2_zero_ff     <= s2_zero_in;
      s2_index_ff    <= s2_index_in;
      s2_fwd_data_ff <= s2_fwd_data_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_index_ff   <= rsp_index_in;
   end

   assign status.init_busy = (state_ff == S_INIT);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tile_count   = rsp_count_ff;
   assign rsp_tile_index   = rsp_index_ff;

   a_sweep_no_update: assert property (@(posedge clock) disable iff (reset)
      !(sweep_we && s2_valid_ff))
      else $error("clear sweep overlaps a count update");

   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      s2_read_ff |-> !rsp_valid_ff)
      else $error("read data arrives while result register is full");

   a_no_pop_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |-> !q_pop)
      else $error("item taken during reset clear");

   a_no_issue_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_RUN) |-> !issue)
      else $error("memory read issued during clear");

endmodule

`default_nettype wire

@@ design/tile_overlap_histogram_unit.sv @@
// count item: four slots in the update sequencer (one read-modify-write slot per cycle)
// read item: the memory read is registered in stage s2, then the result in the response register
// one read in flight at a time, so a read item waits until the last one has left s2 and its result is taken
// clear item: every count entry is zeroed in turn, one count entry zeroed per cycle
// one read-modify-write of the count memory per cycle; a count item leaves the queue after its last slot
// after reset every count entry is zeroed, req_ready low until done
`default_nettype none

module tile_overlap_histogram_unit
   import toh_pkg::*;
#(
   parameter int MAX_TILES   = 4096,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_operation,
   input  wire logic signed [BIN_W-1:0] req_bin_x_low,
   input  wire logic signed [BIN_W-1:0] req_bin_y_low,
   input  wire logic [SPAN-1:0]         req_x_overlap_flags,
   input  wire logic [SPAN-1:0]         req_y_overlap_flags,
   input  wire logic [IDX_W-1:0]        req_read_index,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [OUT_W-1:0]             rsp_tile_count,
   output logic [IDX_W-1:0]             rsp_tile_index,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [BIN_W-1:0]        csr_data
);

   back_status_type status;
   logic            push_valid;
   logic            push_ready;
   work_type        push_data;
   logic            head_valid;
   logic            head_pop;
   work_type        head_data;

   toh_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_bin_x_low       (req_bin_x_low),
      .req_bin_y_low       (req_bin_y_low),
      .req_x_overlap_flags (req_x_overlap_flags),
      .req_y_overlap_flags (req_y_overlap_flags),
      .req_read_index      (req_read_index),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .status              (status),
      .q_valid             (push_valid),
      .q_ready             (push_ready),
      .q_data              (push_data)
   );

   toh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (head_valid),
      .out_ready (head_pop),
      .out_data  (head_data)
   );

   toh_back #(
      .MAX_TILES   (MAX_TILES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (head_valid),
      .q_pop          (head_pop),
      .head           (head_data),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tile_count (rsp_tile_count),
      .rsp_tile_index (rsp_tile_index)
   );

endmodule

`default_nettype wire
